[design/sstf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared types and constants for the shortest-seek-first scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

  // Default sizing
  localparam int QUEUE_DEPTH_DEF   = 32;
  localparam int CYLINDER_BITS_DEF = 16;

  // Fixed field widths of the stream beats
  localparam int CYL_FIELD_W  = 16;
  localparam int DIST_W       = 16;
  localparam int TOTAL_W      = 21;
  localparam int START_W      = 16;
  localparam int OUT_PAYLOAD_W = CYL_FIELD_W + DIST_W + TOTAL_W;
  localparam int OUT_TDATA_W  = ((OUT_PAYLOAD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_PAYLOAD_W;

  // Control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

endpackage

[design/shortest_seek_first_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_seek_first_scheduler
// Collects cylinder requests and emits them in shortest-seek-first order.
// ----------------------------------------------------------------------------
// Requests arrive one per input beat and are written to a request RAM of
// QUEUE_DEPTH entries; a request beyond that is dropped and flagged on the
// first result of the batch. The beat with in_tlast set is stored too and
// starts the schedule from the head position in cfg_wr_data's register.
// Each result is found by one scan of the request RAM, one entry read per
// cycle: the stored requests are read in turn from the registered read,
// then an emit step loads the output register once it is free. Input is
// not accepted while a batch is being scheduled. Ties in seek distance go
// to the earliest stored request. The served marks, count and drop flag
// clear after the final result, which carries out_tlast; the movement sum
// clears when a new batch starts. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module shortest_seek_first_scheduler #(
  parameter int QUEUE_DEPTH   = sstf_pkg::QUEUE_DEPTH_DEF,
  parameter int CYLINDER_BITS = sstf_pkg::CYLINDER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration: start_position
  input  logic                               cfg_wr_en,
  input  logic [sstf_pkg::START_W-1:0]       cfg_wr_data,
  // request stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sstf_pkg::CYL_FIELD_W-1:0]   in_tdata,   // [15:0] request_cylinder
  input  logic                               in_tlast,   // last_request
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] served_cylinder, [31:16] seek_distance, [52:32] total_movement, rest 0
  output logic [sstf_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tuser,  // requests_dropped
  output logic                               out_tlast   // last_served
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CB    = CYLINDER_BITS;
  localparam int SUM_W = sstf_pkg::TOTAL_W;
  localparam int ADD_W = ((CB > SUM_W) ? CB : SUM_W) + 1;

  sstf_pkg::state_t state_r, state_nxt;

  logic [sstf_pkg::START_W-1:0] start_r;

  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [QUEUE_DEPTH-1:0] served_r, served_nxt;
  logic [CB-1:0]          head_r, head_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0]       k_r, k_nxt;       // results emitted so far

  // scan
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic             iss_done_r, iss_done_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             found_r, found_nxt;
  logic [CB-1:0]    best_r, best_nxt;       // best distance
  logic [CB-1:0]    best_cyl_r, best_cyl_nxt;
  logic [IDX_W-1:0] pick_r, pick_nxt;

  // output register
  logic                             out_vld_r, out_vld_nxt;
  logic [sstf_pkg::CYL_FIELD_W-1:0] out_cyl_r, out_cyl_nxt;
  logic [sstf_pkg::DIST_W-1:0]      out_dist_r, out_dist_nxt;
  logic [SUM_W-1:0]                 out_total_r, out_total_nxt;
  logic                             out_drop_r, out_drop_nxt;
  logic                             out_last_r, out_last_nxt;

  logic             in_fire;
  logic             slot_free;
  logic             issue;
  logic             ram_we;
  logic [IDX_W-1:0] last_idx;
  logic [CB-1:0]    rd_data;
  logic [CB-1:0]    seek_dist;
  logic [ADD_W-1:0] sum_ext;
  logic             final_res;
  logic             scan_end;

  assign in_tready = (state_r == sstf_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_vld_r || out_tready;
  assign last_idx  = IDX_W'(count_r - CNT_W'(1));
  assign issue     = (state_r == sstf_pkg::S_SCAN) && !iss_done_r;
  assign ram_we    = in_fire && (count_r < CNT_W'(QUEUE_DEPTH));
  assign scan_end  = rd_vld_r && (rd_idx_r == last_idx);
  assign final_res = ((k_r + CNT_W'(1)) == count_r);

  assign seek_dist = (head_r >= rd_data) ? (head_r - rd_data) : (rd_data - head_r);
  assign sum_ext   = ADD_W'(sum_r) + ADD_W'(best_r);

  sstf_ram #(
    .WIDTH (CB),
    .DEPTH (QUEUE_DEPTH)
  ) u_req_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (CB'(in_tdata)),
    .rd_en   (issue),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sstf_pkg::S_IDLE: begin
        if (in_fire && in_tlast) state_nxt = sstf_pkg::S_SCAN;
      end
      sstf_pkg::S_SCAN: begin
        if (scan_end) state_nxt = sstf_pkg::S_EMIT;
      end
      sstf_pkg::S_EMIT: begin
        if (slot_free) state_nxt = final_res ? sstf_pkg::S_IDLE : sstf_pkg::S_SCAN;
      end
      default: state_nxt = sstf_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    served_nxt    = served_r;
    head_nxt      = head_r;
    sum_nxt       = sum_r;
    k_nxt         = k_r;
    addr_nxt      = addr_r;
    iss_done_nxt  = iss_done_r;
    rd_vld_nxt    = issue;
    rd_idx_nxt    = addr_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_cyl_nxt  = best_cyl_r;
    pick_nxt      = pick_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_cyl_nxt   = out_cyl_r;
    out_dist_nxt  = out_dist_r;
    out_total_nxt = out_total_r;
    out_drop_nxt  = out_drop_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      sstf_pkg::S_IDLE: begin
        if (in_fire) begin
          if (ram_we) count_nxt = count_r + CNT_W'(1);
          else        ovf_nxt   = 1'b1;
          if (in_tlast) begin
            head_nxt     = CB'(start_r);
            sum_nxt      = '0;
            k_nxt        = '0;
            addr_nxt     = '0;
            iss_done_nxt = 1'b0;
            found_nxt    = 1'b0;
          end
        end
      end
      sstf_pkg::S_SCAN: begin
        if (issue) begin
          if (addr_r == last_idx) iss_done_nxt = 1'b1;
          else                    addr_nxt     = addr_r + IDX_W'(1);
        end
        // strict compare keeps the earliest entry on a tie
        if (rd_vld_r && !served_r[rd_idx_r] && (!found_r || seek_dist < best_r)) begin
          found_nxt    = 1'b1;
          best_nxt     = seek_dist;
          best_cyl_nxt = rd_data;
          pick_nxt     = rd_idx_r;
        end
      end
      sstf_pkg::S_EMIT: begin
        if (slot_free) begin
          out_vld_nxt      = 1'b1;
          out_cyl_nxt      = sstf_pkg::CYL_FIELD_W'(best_cyl_r);
          out_dist_nxt     = sstf_pkg::DIST_W'(best_r);
          out_total_nxt    = sum_ext[SUM_W-1:0];
          out_drop_nxt     = (k_r == '0) && ovf_r;
          out_last_nxt     = final_res;
          served_nxt[pick_r] = 1'b1;
          head_nxt         = best_cyl_r;
          sum_nxt          = sum_ext[SUM_W-1:0];
          k_nxt            = k_r + CNT_W'(1);
          addr_nxt         = '0;
          iss_done_nxt     = 1'b0;
          found_nxt        = 1'b0;
          if (final_res) begin
            served_nxt = '0;
            count_nxt  = '0;
            ovf_nxt    = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sstf_pkg::S_IDLE;
      start_r    <= '0;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      served_r   <= '0;
      head_r     <= '0;
      sum_r      <= '0;
      k_r        <= '0;
      addr_r     <= '0;
      iss_done_r <= 1'b0;
      rd_vld_r   <= 1'b0;
      found_r    <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      if (cfg_wr_en) start_r <= cfg_wr_data;
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      served_r   <= served_nxt;
      head_r     <= head_nxt;
      sum_r      <= sum_nxt;
      k_r        <= k_nxt;
      addr_r     <= addr_nxt;
      iss_done_r <= iss_done_nxt;
      rd_vld_r   <= rd_vld_nxt;
      found_r    <= found_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    best_r      <= best_nxt;
    best_cyl_r  <= best_cyl_nxt;
    pick_r      <= pick_nxt;
    out_cyl_r   <= out_cyl_nxt;
    out_dist_r  <= out_dist_nxt;
    out_total_r <= out_total_nxt;
    out_drop_r  <= out_drop_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{sstf_pkg::OUT_PAD_W{1'b0}}, out_total_r, out_dist_r, out_cyl_r};
  assign out_tuser  = out_drop_r;
  assign out_tlast  = out_last_r;

endmodule

[design/sstf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sstf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/sstf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module sstf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sstf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result beat changed");

  // a final request starts scheduling: no further requests taken
  a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("request accepted right after final request");

  // a non-final request yields no result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast && !out_tvalid |=> !out_tvalid)
    else $error("result without final request");

  // drop flag only on the first result of a batch
  a_drop_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> !(out_tvalid && out_tuser))
    else $error("drop flag on a later result");

endmodule

bind shortest_seek_first_scheduler sstf_checker u_sstf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[test/shortest_seek_first_scheduler_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_seek_first_scheduler_tb
// Self-checking bench for the shortest-seek-first request scheduler.
// ----------------------------------------------------------------------------
// Batches of cylinder requests are streamed in, each closed by a beat with
// in_tlast set. Every accepted request beat is fed to a local scheduling
// model, which works out the seek order, distances, running movement and
// drop flag for the batch and queues the expected result beats. Each result
// beat taken from the block is compared field by field with the oldest entry
// of that queue. Directed tests cover single seeks, extreme cylinders and
// head positions, equal-distance ties, a full store with and without
// dropped requests, and a long receiver hold-off. Random batches follow with
// varied sizes, content styles and head positions, with stalls on both sides.
// ----------------------------------------------------------------------------
module shortest_seek_first_scheduler_tb;

  localparam int CYL_FIELD_W  = sstf_pkg::CYL_FIELD_W;
  localparam int DIST_W       = sstf_pkg::DIST_W;
  localparam int TOTAL_W      = sstf_pkg::TOTAL_W;
  localparam int START_W      = sstf_pkg::START_W;
  localparam int OUT_TDATA_W  = sstf_pkg::OUT_TDATA_W;

  localparam int DEPTH        = sstf_pkg::QUEUE_DEPTH_DEF;
  localparam int ITEMS_TARGET = 480;
  // Each result of a full batch takes one scan of the whole store, so a stretch
  // with no beat at all stays well below this even with the receiver stalling.
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 16;

  typedef enum int unsigned {
    FILL_UNIFORM,
    FILL_CLUSTER,
    FILL_MIRROR,
    FILL_EXTREME
  } fill_t;

  typedef enum int unsigned {
    RX_OPEN,
    RX_MOSTLY,
    RX_CYCLIC,
    RX_SPARSE
  } rx_mode_t;

  // One result beat as the block should produce it
  typedef struct {
    logic [CYL_FIELD_W-1:0] cyl;
    logic [DIST_W-1:0]      distance;
    logic [TOTAL_W-1:0]     total;
    logic                   dropped;
    logic                   last;
  } seek_t;

  // Block inputs, all known from time zero
  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [START_W-1:0]     cfg_wr_data = '0;
  logic                   in_tvalid   = 1'b0;
  logic [CYL_FIELD_W-1:0] in_tdata    = '0;
  logic                   in_tlast    = 1'b0;
  logic                   out_tready  = 1'b0;

  wire                    in_tready;
  wire                    out_tvalid;
  wire [OUT_TDATA_W-1:0]  out_tdata;  // [15:0] cyl, [31:16] dist, [52:32] total
  wire                    out_tuser;  // requests_dropped
  wire                    out_tlast;  // last_served

  // Scheduling model state: request store, count, drop flag, head at start
  logic [CYL_FIELD_W-1:0] req_store [DEPTH];
  int unsigned            req_count  = 0;
  logic                   drop_flag  = 1'b0;
  logic [START_W-1:0]     head_start = '0;
  seek_t                  seek_plan [$];

  int unsigned            err_cnt      = 0;
  int unsigned            items_sent   = 0;
  int unsigned            burst_left   = 0;
  int unsigned            quiet_cycles = 0;
  logic                   steady       = 1'b0;  // sender without gaps
  logic                   hold_req     = 1'b0;  // ask receiver for a long hold-off

  shortest_seek_first_scheduler u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scheduling model
  // --------------------------------------------------------------------------
  // Stores one accepted request; a beat with the last flag then plays out the
  // whole batch: nearest unserved request each time, earliest on a tie.
  function automatic void take_request(input logic [CYL_FIELD_W-1:0] cyl,
                                       input logic last);
    logic                   served [DEPTH];
    logic [CYL_FIELD_W-1:0] head;
    logic [DIST_W-1:0]      best;
    logic [DIST_W-1:0]      d;
    logic [TOTAL_W:0]       sum;
    int                     pick;
    seek_t                  s;

    if (req_count < DEPTH) begin
      req_store[req_count] = cyl;
      req_count++;
    end else begin
      drop_flag = 1'b1;  // store full, request lost
    end
    if (!last) return;

    head = head_start;
    sum  = '0;
    best = '0;
    for (int i = 0; i < DEPTH; i++) served[i] = 1'b0;
    for (int k = 0; k < req_count; k++) begin
      pick = -1;
      for (int i = 0; i < req_count; i++) begin
        if (!served[i]) begin
          d = (head >= req_store[i]) ? head - req_store[i] : req_store[i] - head;
          // strict compare keeps the earliest entry on equal distance
          if (pick < 0 || d < best) begin
            best = d;
            pick = i;
          end
        end
      end
      served[pick] = 1'b1;
      sum          = sum + best;
      head         = req_store[pick];
      s.cyl        = head;
      s.distance   = best;
      s.total      = sum[TOTAL_W-1:0];
      s.dropped    = (k == 0) && drop_flag;
      s.last       = (k == req_count - 1);
      seek_plan.insert(seek_plan.size(), s);
    end
    req_count = 0;
    drop_flag = 1'b0;
  endfunction

  // Request monitor: every accepted beat goes into the model
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) take_request(in_tdata, in_tlast);
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  task automatic cmp_field(input string name, input logic [31:0] want,
                           input logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    seek_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (seek_plan.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result beat, expected none, got cyl %0d dist %0d",
                 $time, out_tdata[15:0], out_tdata[31:16]);
      end else begin
        want = seek_plan.pop_front();
        cmp_field("served_cylinder",  32'(want.cyl),      32'(out_tdata[15:0]));
        cmp_field("seek_distance",    32'(want.distance), 32'(out_tdata[31:16]));
        cmp_field("total_movement",   32'(want.total),    32'(out_tdata[52:32]));
        cmp_field("requests_dropped", 32'(want.dropped),  32'(out_tuser));
        cmp_field("last_served",      32'(want.last),     32'(out_tlast));
      end
    end
  end

  // Watchdog: too long without any beat on either side ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: changing stall patterns, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned tick;
    mode      = RX_OPEN;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
          RX_CYCLIC: out_tready <= ((tick % 5) != 0);
          default:   out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Bursts of random length; between bursts valid drops for a random pause
  // unless the sender is in a steady stretch. Valid stays high from one beat
  // to the next within a burst.
  task automatic send_req(input logic [CYL_FIELD_W-1:0] cyl, input logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!steady) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= cyl;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Sender pauses until every expected result has arrived, then lets the
  // block settle.
  task automatic wait_idle;
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (seek_plan.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle
  task automatic write_start(input logic [START_W-1:0] pos);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= pos;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    head_start = pos;
  endtask

  task automatic send_batch(input int unsigned n, input fill_t fill);
    logic [CYL_FIELD_W-1:0] base;
    logic [CYL_FIELD_W-1:0] cyl;
    logic [CYL_FIELD_W-1:0] d;
    base = CYL_FIELD_W'($urandom);
    for (int unsigned i = 0; i < n; i++) begin
      case (fill)
        FILL_UNIFORM: cyl = CYL_FIELD_W'($urandom);
        // dense range: duplicates and many near ties
        FILL_CLUSTER: cyl = base + CYL_FIELD_W'($urandom_range(0, 15));
        // mirrored around the head: exact ties on distance
        FILL_MIRROR: begin
          d   = CYL_FIELD_W'($urandom_range(0, 3) * $urandom_range(1, 5));
          cyl = $urandom_range(0, 1) ? head_start + d : head_start - d;
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       cyl = '0;
            1:       cyl = '1;
            2:       cyl = head_start;
            default: cyl = CYL_FIELD_W'($urandom);
          endcase
        end
      endcase
      send_req(cyl, i == n - 1);
    end
  endtask

  // Mostly small batches, a few up to a full store and the odd overflowing one
  function automatic int unsigned pick_size;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 90) return $urandom_range(9, 20);
    if (r < 98) return $urandom_range(21, DEPTH);
    return $urandom_range(DEPTH + 1, DEPTH + 8);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // One-request batches at both ends of the cylinder range, head at both ends
  task automatic test_single_seek;
    send_req('0, 1'b1);
    send_req('1, 1'b1);
    wait_idle();
    write_start('1);
    send_req('0, 1'b1);
    send_req('1, 1'b1);
    wait_idle();
  endtask

  // Equal distances either side of the head: first stored must win
  task automatic test_equal_distance;
    write_start(16'd1000);
    send_req(16'd1010, 1'b0);
    send_req(16'd990,  1'b0);
    send_req(16'd1010, 1'b0);
    send_req(16'd990,  1'b0);
    send_req(16'd1000, 1'b1);
    wait_idle();
  endtask

  // Extreme cylinders with the head in the middle of the range
  task automatic test_extremes;
    write_start(16'h8000);
    send_req(16'h0000, 1'b0);
    send_req(16'hFFFF, 1'b0);
    send_req(16'h8000, 1'b0);
    send_req(16'h0001, 1'b0);
    send_req(16'hFFFE, 1'b0);
    send_req(16'h8000, 1'b1);
    wait_idle();
  endtask

  // Store exactly full, full with the last beat dropped, and well over full
  task automatic test_full_store;
    write_start(START_W'($urandom));
    send_batch(DEPTH, FILL_UNIFORM);
    send_batch(DEPTH + 1, FILL_UNIFORM);
    send_batch(DEPTH + 8, FILL_EXTREME);
    wait_idle();
  endtask

  // Receiver held off while the sender keeps going: the output register fills,
  // then the block stalls its input during scheduling until the hold-off ends.
  task automatic test_backpressure;
    write_start(16'h0000);
    steady   = 1'b1;
    hold_req = 1'b1;
    send_batch(12, FILL_UNIFORM);
    send_batch(6, FILL_CLUSTER);
    send_batch(20, FILL_MIRROR);
    wait_idle();
    steady = 1'b0;
  endtask

  task automatic test_random_batches;
    int unsigned batch_no;
    int unsigned r;
    batch_no = 0;
    while (items_sent < ITEMS_TARGET) begin
      if (batch_no % 4 == 0) begin
        wait_idle();
        r = $urandom_range(0, 9);
        if (r == 0)      write_start('0);
        else if (r == 1) write_start('1);
        else             write_start(START_W'($urandom));
        steady = ($urandom_range(0, 3) == 0);
      end
      send_batch(pick_size(), fill_t'($urandom_range(0, 3)));
      batch_no++;
    end
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_seek();
    test_equal_distance();
    test_extremes();
    test_full_store();
    test_backpressure();
    test_random_batches();

    // catch any stray beat after the last expected one
    repeat (4 * DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && seek_plan.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
